FILE: sv/bvm_pkg.sv
package bvm_pkg;

	localparam int ADC_BITS     = 12;
	localparam int SAMPLE_LOG2  = 4;
	localparam int SAMPLE_COUNT = 1 << SAMPLE_LOG2;
	localparam int IDX_W        = SAMPLE_LOG2;
	localparam int SUM_W        = ADC_BITS + SAMPLE_LOG2;

	localparam int MV_W   = 16;
	localparam int GAIN_W = 16;
	localparam int CELL_W = 4;
	localparam int CHG_W  = 10;
	localparam int CNT_W  = 32;
	localparam int PROD_W = 2 * MV_W;
	localparam int DIVD_W = 26;
	localparam int STEP_W = 5;

	localparam logic [CHG_W-1:0]  CHG_FULL = CHG_W'(1000);
	localparam logic [MV_W-1:0]   MV_SAT   = '1;
	localparam logic [MV_W-1:0]   PCT_SCALE = MV_W'(1000);
	localparam logic [STEP_W-1:0] CHG_STEPS  = STEP_W'(DIVD_W);
	localparam logic [STEP_W-1:0] CELL_STEPS = STEP_W'(MV_W);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd2268;
	localparam logic [MV_W-1:0]   MIN_RST   = 16'd13200;
	localparam logic [MV_W-1:0]   MAX_RST   = 16'd16800;
	localparam logic [MV_W-1:0]   CRIT_RST  = 16'd12800;
	localparam logic [CELL_W-1:0] CELLS_RST = 4'd4;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

endpackage

FILE: sv/bvm_in_if.sv
interface bvm_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [bvm_pkg::ADC_BITS-1:0]  adc_sample;
	logic                          sample_good;

	modport source(output valid, op, adc_sample, sample_good, input ready);
	modport sink(input valid, op, adc_sample, sample_good, output ready);
endinterface

FILE: sv/bvm_out_if.sv
interface bvm_out_if;
	logic                          valid;
	logic                          ready;
	logic [bvm_pkg::ADC_BITS-1:0]  average_count;
	logic [bvm_pkg::MV_W-1:0]      pack_millivolts;
	logic [bvm_pkg::CHG_W-1:0]     charge_tenths;
	logic [bvm_pkg::MV_W-1:0]      cell_millivolts;
	logic                          is_ok;
	logic                          is_low;
	logic                          is_critical;
	logic [bvm_pkg::CNT_W-1:0]     check_total;
	logic [bvm_pkg::CNT_W-1:0]     critical_total;

	modport source(output valid, average_count, pack_millivolts, charge_tenths,
		cell_millivolts, is_ok, is_low, is_critical, check_total, critical_total,
		input ready);
	modport sink(input valid, average_count, pack_millivolts, charge_tenths,
		cell_millivolts, is_ok, is_low, is_critical, check_total, critical_total,
		output ready);
endinterface

FILE: sv/bvm_cfg_if.sv
interface bvm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bvm_pkg::CFG_IDX_W-1:0]  index;
	logic [bvm_pkg::CFG_DAT_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/battery_voltage_monitor_unit.sv
// A word that closes a 16-sample window starts a check: gain scaling, flags, then cell
// voltage division if the voltage is at or below min or at or above max, else charge
// multiply and division first. Words are taken only while idle; one check at a time,
// set by the shared 16x16 multiplier and shared one-bit-per-cycle restoring divider.
// Reset (arst_n low): registers to defaults, sum, sample count and counters to zero.
module battery_voltage_monitor_unit (
	input  logic           clk,
	input  logic           arst_n,
	bvm_in_if.sink         in_ch,
	bvm_out_if.source      out_ch,
	bvm_cfg_if.sink        cfg
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCALE, S_FLAGS, S_CMUL, S_CDIV, S_VDIV, S_DONE
	} state_t;

	state_t state_q;

	logic [bvm_pkg::GAIN_W-1:0]   gain_q;
	logic [bvm_pkg::MV_W-1:0]     min_q, max_q, crit_thr_q;
	logic [bvm_pkg::CELL_W-1:0]   cells_q;

	logic [bvm_pkg::SUM_W-1:0]    sum_q;
	logic [bvm_pkg::IDX_W-1:0]    idx_q;
	logic [bvm_pkg::CNT_W-1:0]    chk_q, crit_cnt_q;

	logic [bvm_pkg::ADC_BITS-1:0] avg_q;
	logic [bvm_pkg::MV_W-1:0]     mv_q, diff_q;
	logic [bvm_pkg::CHG_W-1:0]    chg_q;
	logic                         ok_q, low_q, crit_q;

	logic [bvm_pkg::DIVD_W-1:0]   dvd_q;
	logic [bvm_pkg::MV_W-1:0]     rem_q, dsr_q;
	logic [bvm_pkg::STEP_W-1:0]   step_q;

	logic                         o_vld_q;
	logic [bvm_pkg::ADC_BITS-1:0] o_avg_q;
	logic [bvm_pkg::MV_W-1:0]     o_mv_q, o_cell_q;
	logic [bvm_pkg::CHG_W-1:0]    o_chg_q;
	logic                         o_ok_q, o_low_q, o_crit_q;
	logic [bvm_pkg::CNT_W-1:0]    o_chk_q, o_crit_cnt_q;

	logic                         in_acc, out_acc, cfg_acc;
	logic [bvm_pkg::SUM_W-1:0]    sum_nxt;
	logic [bvm_pkg::MV_W-1:0]     mul_a, mul_b;
	logic [bvm_pkg::PROD_W-1:0]   prod;
	logic [bvm_pkg::MV_W:0]       rem_sh;
	logic                         q_bit;
	logic [bvm_pkg::MV_W-1:0]     rem_nxt;
	logic [bvm_pkg::DIVD_W-1:0]   dvd_nxt;
	logic [bvm_pkg::MV_W-1:0]     cell_dsr;
	logic                         crit_now;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign cfg_acc = cfg.valid && cfg.ready;

	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	assign sum_nxt = sum_q + (in_ch.sample_good ?
		bvm_pkg::SUM_W'(in_ch.adc_sample) : '0);

	// shared multiplier: gain scaling, then percent scaling
	assign mul_a = (state_q == S_SCALE) ? bvm_pkg::MV_W'(avg_q) : diff_q;
	assign mul_b = (state_q == S_SCALE) ? gain_q : bvm_pkg::PCT_SCALE;
	assign prod  = mul_a * mul_b;

	// shared restoring divider, one quotient bit per cycle
	assign rem_sh  = {rem_q, dvd_q[bvm_pkg::DIVD_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, dsr_q});
	assign rem_nxt = q_bit ? bvm_pkg::MV_W'(rem_sh - {1'b0, dsr_q})
		: rem_sh[bvm_pkg::MV_W-1:0];
	assign dvd_nxt = {dvd_q[bvm_pkg::DIVD_W-2:0], q_bit};

	assign cell_dsr = (cells_q == '0) ? bvm_pkg::MV_W'(1) : bvm_pkg::MV_W'(cells_q);
	assign crit_now = (mv_q <= crit_thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= bvm_pkg::GAIN_RST;
			min_q      <= bvm_pkg::MIN_RST;
			max_q      <= bvm_pkg::MAX_RST;
			crit_thr_q <= bvm_pkg::CRIT_RST;
			cells_q    <= bvm_pkg::CELLS_RST;
		end else if (cfg_acc) begin
			unique case (cfg.index)
				bvm_pkg::REG_GAIN:  gain_q     <= cfg.data;
				bvm_pkg::REG_MIN:   min_q      <= cfg.data;
				bvm_pkg::REG_MAX:   max_q      <= cfg.data;
				bvm_pkg::REG_CRIT:  crit_thr_q <= cfg.data;
				bvm_pkg::REG_CELLS: cells_q    <= cfg.data[bvm_pkg::CELL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sum_q      <= '0;
			idx_q      <= '0;
			chk_q      <= '0;
			crit_cnt_q <= '0;
			o_vld_q    <= 1'b0;
		end else begin
			if (out_acc && state_q != S_DONE)
				o_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.op == bvm_pkg::OP_CLEAR) begin
							chk_q      <= '0;
							crit_cnt_q <= '0;
						end else if (idx_q == bvm_pkg::IDX_W'(bvm_pkg::SAMPLE_COUNT - 1)) begin
							avg_q   <= sum_nxt[bvm_pkg::SUM_W-1:bvm_pkg::SAMPLE_LOG2];
							sum_q   <= '0;
							idx_q   <= '0;
							state_q <= S_SCALE;
						end else begin
							sum_q <= sum_nxt;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SCALE: begin
					mv_q    <= (prod[bvm_pkg::PROD_W-1:bvm_pkg::MV_W+8] != '0) ? bvm_pkg::MV_SAT
						: prod[bvm_pkg::MV_W+7:8];
					state_q <= S_FLAGS;
				end
				S_FLAGS: begin
					crit_q <= crit_now;
					low_q  <= (mv_q <= min_q);
					ok_q   <= (mv_q > min_q) && (mv_q <= max_q);
					chk_q  <= chk_q + 1'b1;
					if (crit_now)
						crit_cnt_q <= crit_cnt_q + 1'b1;
					diff_q <= mv_q - min_q;
					priority if (mv_q <= min_q) begin
						chg_q   <= '0;
						dvd_q   <= {mv_q, {(bvm_pkg::DIVD_W-bvm_pkg::MV_W){1'b0}}};
						rem_q   <= '0;
						dsr_q   <= cell_dsr;
						step_q  <= bvm_pkg::CELL_STEPS;
						state_q <= S_VDIV;
					end else if (mv_q >= max_q) begin
						chg_q   <= bvm_pkg::CHG_FULL;
						dvd_q   <= {mv_q, {(bvm_pkg::DIVD_W-bvm_pkg::MV_W){1'b0}}};
						rem_q   <= '0;
						dsr_q   <= cell_dsr;
						step_q  <= bvm_pkg::CELL_STEPS;
						state_q <= S_VDIV;
					end else begin
						dsr_q   <= max_q - min_q;
						state_q <= S_CMUL;
					end
				end
				S_CMUL: begin
					dvd_q   <= prod[bvm_pkg::DIVD_W-1:0];
					rem_q   <= '0;
					step_q  <= bvm_pkg::CHG_STEPS;
					state_q <= S_CDIV;
				end
				S_CDIV: begin
					if (step_q == bvm_pkg::STEP_W'(1)) begin
						chg_q   <= dvd_nxt[bvm_pkg::CHG_W-1:0];
						dvd_q   <= {mv_q, {(bvm_pkg::DIVD_W-bvm_pkg::MV_W){1'b0}}};
						rem_q   <= '0;
						dsr_q   <= cell_dsr;
						step_q  <= bvm_pkg::CELL_STEPS;
						state_q <= S_VDIV;
					end else begin
						dvd_q  <= dvd_nxt;
						rem_q  <= rem_nxt;
						step_q <= step_q - 1'b1;
					end
				end
				S_VDIV: begin
					dvd_q  <= dvd_nxt;
					rem_q  <= rem_nxt;
					step_q <= step_q - 1'b1;
					if (step_q == bvm_pkg::STEP_W'(1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (!o_vld_q || out_ch.ready) begin
						o_vld_q      <= 1'b1;
						o_avg_q      <= avg_q;
						o_mv_q       <= mv_q;
						o_chg_q      <= chg_q;
						o_cell_q     <= dvd_q[bvm_pkg::MV_W-1:0];
						o_ok_q       <= ok_q;
						o_low_q      <= low_q;
						o_crit_q     <= crit_q;
						o_chk_q      <= chk_q;
						o_crit_cnt_q <= crit_cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid           = o_vld_q;
	assign out_ch.average_count   = o_avg_q;
	assign out_ch.pack_millivolts = o_mv_q;
	assign out_ch.charge_tenths   = o_chg_q;
	assign out_ch.cell_millivolts = o_cell_q;
	assign out_ch.is_ok           = o_ok_q;
	assign out_ch.is_low          = o_low_q;
	assign out_ch.is_critical     = o_crit_q;
	assign out_ch.check_total     = o_chk_q;
	assign out_ch.critical_total  = o_crit_cnt_q;

	a_window_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.op == bvm_pkg::OP_SAMPLE
			&& idx_q == bvm_pkg::IDX_W'(bvm_pkg::SAMPLE_COUNT - 1)) |=> state_q == S_SCALE)
		else $error("closing sample did not start a check");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.op == bvm_pkg::OP_CLEAR) |=> (chk_q == '0 && crit_cnt_q == '0))
		else $error("clear did not zero the counters");

	a_check_counts_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLAGS) |=> chk_q == $past(chk_q) + 1'b1)
		else $error("check counter did not advance by one");

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		o_vld_q |-> o_chg_q <= bvm_pkg::CHG_FULL)
		else $error("charge above full scale");

endmodule
